### sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the bitmap block allocator
// Request and status codes, controller states, and the command and status
// groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 8192;

  // Field widths of the request, result and register interfaces.
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 13;
  localparam int STS_W   = 2;
  localparam int COUNT_W = 14;
  localparam int RES_W   = 14;

  localparam logic [RES_W-1:0] RESERVED_RESET = 14'd261;

  // Map geometry: 64-bit words, scanned a byte at a time.
  localparam int WORD_BITS  = 64;
  localparam int BYTE_BITS  = 8;
  localparam int GRP_WORDS  = 16;
  localparam int GRP_IDX_W  = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_FORMAT = 2'd2
  } req_t;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NONE    = 2'd1;
  localparam logic [STS_W-1:0] STS_ALREADY = 2'd2;
  localparam logic [STS_W-1:0] STS_RANGE   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AGRP,
    S_AWORD,
    S_ARD,
    S_ALOAD,
    S_ABYTE,
    S_ABIT,
    S_FADDR,
    S_FRD,
    S_FLOAD,
    S_FCHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic format;
    logic grp_find;
    logic word_find;
    logic set_none;
    logic chk_idx;
    logic rd_req;
    logic load_word;
    logic byte_find;
    logic alloc_upd;
    logic free_upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic grp_any;
    logic idx_bad;
    logic out_free;
  } sts_t;

endpackage

### sv/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl: request sequencer for the bitmap block allocator
// Steps each request through its scan, read, update and response phases.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [bba_pkg::REQ_W-1:0]  in_req_type,
  output logic                       in_ready,
  input  bba_pkg::sts_t              sts,
  output bba_pkg::cmd_t              cmd
);

  import bba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_ALLOC: state_nxt = S_AGRP;
            REQ_FREE:  state_nxt = S_FADDR;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_AGRP:  state_nxt = S_AWORD;
      S_AWORD: state_nxt = sts.grp_any ? S_ARD : S_RESP;
      S_ARD:   state_nxt = S_ALOAD;
      S_ALOAD: state_nxt = S_ABYTE;
      S_ABYTE: state_nxt = S_ABIT;
      S_ABIT:  state_nxt = S_RESP;
      S_FADDR: state_nxt = sts.idx_bad ? S_RESP : S_FRD;
      S_FRD:   state_nxt = S_FLOAD;
      S_FLOAD: state_nxt = S_FCHK;
      S_FCHK:  state_nxt = S_RESP;
      S_RESP:  state_nxt = sts.out_free ? S_IDLE : S_RESP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.format = (in_req_type == REQ_FORMAT);
        end
      end
      S_AGRP: cmd.grp_find = 1'b1;
      S_AWORD: begin
        cmd.word_find = sts.grp_any;
        cmd.set_none  = !sts.grp_any;
      end
      S_ARD, S_FRD:     cmd.rd_req    = 1'b1;
      S_ALOAD, S_FLOAD: cmd.load_word = 1'b1;
      S_ABYTE: cmd.byte_find = 1'b1;
      S_ABIT:  cmd.alloc_upd = 1'b1;
      S_FADDR: cmd.chk_idx   = 1'b1;
      S_FCHK:  cmd.free_upd  = 1'b1;
      S_RESP:  cmd.load_out  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### sv/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp: datapath of the bitmap block allocator
// Holds the free map RAM, per-word valid and summary bits, the free count,
// the find-first scan registers and the result register.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bba_pkg::cmd_t                cmd,
  output bba_pkg::sts_t                sts,
  input  logic [bba_pkg::IDX_W-1:0]    in_block_index,
  input  logic                         cfg_we,
  input  logic [bba_pkg::RES_W-1:0]    cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bba_pkg::STS_W-1:0]    out_status,
  output logic [bba_pkg::IDX_W-1:0]    out_allocated_index,
  output logic [bba_pkg::COUNT_W-1:0]  out_free_count
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int NUM_GRP   = (MAP_WORDS + GRP_WORDS - 1) / GRP_WORDS;
  localparam int GW        = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int SUM_W     = NUM_GRP * GRP_WORDS;
  localparam int NBYTES    = WORD_BITS / BYTE_BITS;
  localparam int BYW       = $clog2(NBYTES);
  localparam int BTW       = $clog2(BYTE_BITS);

  // Reserved count limited to the map size.
  function automatic logic [CNT_W-1:0] clamp_res(input logic [RES_W-1:0] r);
    if (int'(r) >= NUM_BLOCKS) begin
      return CNT_W'(NUM_BLOCKS);
    end
    return CNT_W'(r);
  endfunction

  // Contents of a word as a format with reserve res leaves it.
  function automatic logic [WORD_BITS-1:0] fmt_word(input logic [AW-1:0] w,
                                                    input logic [CNT_W-1:0] res);
    int base;
    logic [WORD_BITS-1:0] v;
    base = int'(w) * WORD_BITS;
    for (int b = 0; b < WORD_BITS; b++) begin
      v[b] = ((base + b) >= int'(res)) && ((base + b) < NUM_BLOCKS);
    end
    return v;
  endfunction

  // Words holding a free bit right after a format.
  function automatic logic [SUM_W-1:0] fmt_sum(input logic [CNT_W-1:0] res);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int w = 0; w < MAP_WORDS; w++) begin
      s[w] = (int'(res) < NUM_BLOCKS) && ((int'(res) / WORD_BITS) <= w);
    end
    return s;
  endfunction

  localparam logic [CNT_W-1:0] RES_RST = clamp_res(RESERVED_RESET);

  logic [RES_W-1:0]     reserved_r;
  logic [CNT_W-1:0]     fmt_res_r;
  logic [CNT_W-1:0]     fmt_res_nxt;
  logic [MAP_WORDS-1:0] valid_r;
  logic [SUM_W-1:0]     summary_r;
  logic [CNT_W-1:0]     free_total_r;
  logic [IDX_W-1:0]     idx_r;
  logic [STS_W-1:0]     status_r;
  logic [IDX_W-1:0]     granted_r;
  logic [GW-1:0]        grp_sel_r;
  logic                 grp_any_r;
  logic [AW-1:0]        word_idx_r;
  logic [WORD_BITS-1:0] word_r;
  logic [BYW-1:0]       byte_sel_r;
  logic [BYTE_BITS-1:0] byte_r;

  logic                 out_valid_r;
  logic [STS_W-1:0]     out_status_r;
  logic [IDX_W-1:0]     out_alloc_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic [NUM_GRP-1:0]   grp_flag;
  logic [GW-1:0]        grp_first;
  logic [GRP_WORDS-1:0] grp_bits;
  logic [GRP_IDX_W-1:0] word_first;
  logic [NBYTES-1:0]    byte_flag;
  logic [BYW-1:0]       byte_first;
  logic [BTW-1:0]       bit_first;
  logic [BYW+BTW-1:0]   alloc_pos;
  logic [BYW+BTW-1:0]   free_pos;
  logic [WORD_BITS-1:0] alloc_word;
  logic [WORD_BITS-1:0] free_word;
  logic                 free_hit;
  logic [AW-1:0]        idx_word;
  logic                 idx_bad;
  logic [31:0]          gnt_ext;
  logic [31:0]          cnt_ext;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  assign fmt_res_nxt = clamp_res(reserved_r);

  // Two-level find-first over the summary bits: group, then word in group.
  always_comb begin
    grp_first = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_flag[g] = |summary_r[g*GRP_WORDS +: GRP_WORDS];
    end
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_flag[g]) begin
        grp_first = GW'(g);
      end
    end
  end

  assign grp_bits = summary_r[{grp_sel_r, {GRP_IDX_W{1'b0}}} +: GRP_WORDS];

  always_comb begin
    word_first = '0;
    for (int i = GRP_WORDS - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        word_first = GRP_IDX_W'(i);
      end
    end
  end

  // Within the loaded word: first nonzero byte, then first set bit.
  always_comb begin
    byte_first = '0;
    for (int k = 0; k < NBYTES; k++) begin
      byte_flag[k] = |word_r[k*BYTE_BITS +: BYTE_BITS];
    end
    for (int k = NBYTES - 1; k >= 0; k--) begin
      if (byte_flag[k]) begin
        byte_first = BYW'(k);
      end
    end
  end

  always_comb begin
    bit_first = '0;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (byte_r[i]) begin
        bit_first = BTW'(i);
      end
    end
  end

  assign alloc_pos  = {byte_sel_r, bit_first};
  assign alloc_word = word_r & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << alloc_pos);
  assign free_pos   = idx_r[BYW+BTW-1:0];
  assign free_hit   = word_r[free_pos];
  assign free_word  = word_r | ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_pos);
  assign idx_word   = AW'(idx_r[IDX_W-1:BYW+BTW]);
  assign idx_bad    = (32'(idx_r) >= NUM_BLOCKS);
  assign gnt_ext    = 32'({word_idx_r, alloc_pos});
  assign cnt_ext    = 32'(free_total_r);

  assign ram_we    = cmd.alloc_upd || (cmd.free_upd && !free_hit);
  assign ram_wdata = cmd.alloc_upd ? alloc_word : free_word;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_idx_r),
    .wdata (ram_wdata),
    .re    (cmd.rd_req),
    .raddr (word_idx_r),
    .rdata (ram_rdata)
  );

  // Map state. A word whose valid bit is clear reads as its format value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r   <= RESERVED_RESET;
      fmt_res_r    <= RES_RST;
      valid_r      <= '0;
      summary_r    <= fmt_sum(RES_RST);
      free_total_r <= CNT_W'(NUM_BLOCKS - int'(RES_RST));
    end else begin
      if (cfg_we) begin
        reserved_r <= cfg_wdata;
      end
      if (cmd.format) begin
        fmt_res_r    <= fmt_res_nxt;
        valid_r      <= '0;
        summary_r    <= fmt_sum(fmt_res_nxt);
        free_total_r <= CNT_W'(NUM_BLOCKS - int'(fmt_res_nxt));
      end else if (cmd.alloc_upd) begin
        valid_r[word_idx_r]   <= 1'b1;
        summary_r[word_idx_r] <= |alloc_word;
        if (free_total_r != '0) begin
          free_total_r <= free_total_r - 1'b1;
        end
      end else if (cmd.free_upd && !free_hit) begin
        valid_r[word_idx_r]   <= 1'b1;
        summary_r[word_idx_r] <= 1'b1;
        free_total_r          <= free_total_r + 1'b1;
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r     <= in_block_index;
      status_r  <= STS_OK;
      granted_r <= '0;
    end
    if (cmd.grp_find) begin
      grp_sel_r <= grp_first;
      grp_any_r <= |grp_flag;
    end
    if (cmd.word_find) begin
      word_idx_r <= AW'({grp_sel_r, word_first});
    end
    if (cmd.set_none) begin
      status_r <= STS_NONE;
    end
    if (cmd.chk_idx) begin
      word_idx_r <= idx_word;
      if (idx_bad) begin
        status_r <= STS_RANGE;
      end
    end
    if (cmd.load_word) begin
      word_r <= valid_r[word_idx_r] ? ram_rdata : fmt_word(word_idx_r, fmt_res_r);
    end
    if (cmd.byte_find) begin
      byte_sel_r <= byte_first;
      byte_r     <= word_r[{byte_first, {BTW{1'b0}}} +: BYTE_BITS];
    end
    if (cmd.alloc_upd) begin
      granted_r <= gnt_ext[IDX_W-1:0];
    end
    if (cmd.free_upd && free_hit) begin
      status_r <= STS_ALREADY;
    end
  end

  // Result register; a new result can load in the cycle the old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_alloc_r  <= granted_r;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign sts.grp_any  = grp_any_r;
  assign sts.idx_bad  = idx_bad;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_index = out_alloc_r;
  assign out_free_count      = out_count_r;

endmodule

### sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit free block allocator
// Keeps a free bitmap and free count; serves allocate, free and format.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with in_req_type and in_block_index;
// each one yields exactly one result on out_valid/out_ready carrying
// out_status, out_allocated_index and out_free_count. One request is worked
// at a time; the result is shown in the same cycle as the next request can
// be accepted. An allocate steps through the scan: group summary, word
// summary, a map RAM read with registered data, then first nonzero byte and
// first set bit; on a full map it answers after the summaries. A free checks
// the index range, then pays the RAM read and the bit check. Format and
// unknown requests go straight to the result.
// cfg_we/cfg_wdata write reserved_blocks; only the next format uses it.
// Format needs no clearing pass: per-word valid bits are cleared, and
// unwritten words read as their formatted value.
// Reset (rst_n low, synchronous) leaves the map formatted with 261 reserved
// blocks and ready for a request once rst_n is released.
// If the receiver stalls, the result register holds; the block still takes
// and works one more request and then waits to deliver its result.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bba_pkg::REQ_W-1:0]    in_req_type,
  input  logic [bba_pkg::IDX_W-1:0]    in_block_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bba_pkg::STS_W-1:0]    out_status,
  output logic [bba_pkg::IDX_W-1:0]    out_allocated_index,
  output logic [bba_pkg::COUNT_W-1:0]  out_free_count,
  input  logic                         cfg_we,
  input  logic [bba_pkg::RES_W-1:0]    cfg_wdata
);

  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  bba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_block_index      (in_block_index),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_allocated_index (out_allocated_index),
    .out_free_count      (out_free_count)
  );

endmodule

### sv/bba_chk.sv
// ----------------------------------------------------------------------------
// bba_chk: port-level checks for the bitmap block allocator
// Watches the top-level ports and is attached by the bind at the end.
// ----------------------------------------------------------------------------
module bba_chk #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bba_pkg::STS_W-1:0]    out_status,
  input logic [bba_pkg::IDX_W-1:0]    out_allocated_index,
  input logic [bba_pkg::COUNT_W-1:0]  out_free_count
);

  import bba_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_allocated_index) && $stable(out_free_count))
    else $error("result changed while stalled");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A full map reports no grant and a zero count.
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_NONE) |->
      (out_free_count == '0) && (out_allocated_index == '0))
    else $error("no-free result with nonzero count or index");

  // The free count never exceeds the map size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_free_count) <= NUM_BLOCKS))
    else $error("free count above block count");

endmodule

bind bitmap_block_allocator bba_chk #(.NUM_BLOCKS(NUM_BLOCKS)) u_bba_chk (.*);
